// ----- hdl/pmlc_pkg.sv -----
package pmlc_pkg;

    // default parameter values
    localparam int ADC_BITS_DEF    = 12;
    localparam int ENERGY_BITS_DEF = 48;

    // item commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_MANUAL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 1'b1;

    // field widths
    localparam int T_W     = 8;         // kept ADC bits
    localparam int X_W     = 2 * T_W;   // v*i product of the top bits
    localparam int VOLT_W  = 18;
    localparam int AMP_W   = 14;
    localparam int POW_W   = 22;
    localparam int TOTAL_W = 23;
    localparam int THR_W   = 23;
    localparam int HOLD_W  = 16;

    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(1500000);
    localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(8000);

    // Scaling by reciprocal: floor(x*NUM/DEN) = (x*ceil(NUM*2^SH/DEN)) >> SH,
    // exact while x_max*DEN < 2^SH.
    // volt: t*240000/255 = t*16000/17
    localparam longint unsigned VOLT_NUM = 16000;
    localparam longint unsigned VOLT_DEN = 17;
    localparam int              VOLT_SH  = 16;
    localparam longint unsigned VOLT_MUL =
        ((VOLT_NUM << VOLT_SH) + VOLT_DEN - 1) / VOLT_DEN;
    localparam int VOLT_MUL_W = $clog2(VOLT_MUL + 1);
    localparam int VOLT_PW    = T_W + VOLT_MUL_W;
    localparam logic [VOLT_MUL_W-1:0] VOLT_MUL_C = VOLT_MUL_W'(VOLT_MUL);

    // amp: t*10000/255 = t*2000/51
    localparam longint unsigned AMP_NUM = 2000;
    localparam longint unsigned AMP_DEN = 51;
    localparam int              AMP_SH  = 16;
    localparam longint unsigned AMP_MUL =
        ((AMP_NUM << AMP_SH) + AMP_DEN - 1) / AMP_DEN;
    localparam int AMP_MUL_W = $clog2(AMP_MUL + 1);
    localparam int AMP_PW    = T_W + AMP_MUL_W;
    localparam logic [AMP_MUL_W-1:0] AMP_MUL_C = AMP_MUL_W'(AMP_MUL);

    // power: x*2400000/65025 = x*32000/867
    localparam longint unsigned PWR_NUM = 32000;
    localparam longint unsigned PWR_DEN = 867;
    localparam int              PWR_SH  = 26;
    localparam longint unsigned PWR_MUL =
        ((PWR_NUM << PWR_SH) + PWR_DEN - 1) / PWR_DEN;
    localparam int PWR_MUL_W = $clog2(PWR_MUL + 1);
    localparam int PWR_PW    = X_W + PWR_MUL_W;
    localparam logic [PWR_MUL_W-1:0] PWR_MUL_C = PWR_MUL_W'(PWR_MUL);

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic mul_en;    // top-bit products
        logic scale_en;  // power scaling
        logic sum_en;    // phase sum
        logic commit;    // state update and result load
    } t_dp_ctl;

endpackage

// ----- hdl/pmlc_chan_if.sv -----
interface pmlc_in_if #(
    parameter int ADC_BITS = pmlc_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [ADC_BITS-1:0] adc_v1;
    logic [ADC_BITS-1:0] adc_i1;
    logic [ADC_BITS-1:0] adc_v2;
    logic [ADC_BITS-1:0] adc_i2;
    logic                manual_on;

    modport source (output valid, cmd, adc_v1, adc_i1, adc_v2, adc_i2, manual_on,
                    input ready);
    modport sink   (input valid, cmd, adc_v1, adc_i1, adc_v2, adc_i2, manual_on,
                    output ready);
endinterface

interface pmlc_out_if #(
    parameter int ENERGY_BITS = pmlc_pkg::ENERGY_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [pmlc_pkg::VOLT_W-1:0]         volt1_mv;
    logic [pmlc_pkg::AMP_W-1:0]          amp1_ma;
    logic [pmlc_pkg::POW_W-1:0]          pow1_mw;
    logic [pmlc_pkg::VOLT_W-1:0]         volt2_mv;
    logic [pmlc_pkg::AMP_W-1:0]          amp2_ma;
    logic [pmlc_pkg::POW_W-1:0]          pow2_mw;
    logic [pmlc_pkg::TOTAL_W-1:0]        total_mw;
    logic [ENERGY_BITS-1:0]              energy_halfmj;
    logic                                relay_level;
    logic                                override_active;

    modport source (output valid, volt1_mv, amp1_ma, pow1_mw, volt2_mv, amp2_ma,
                    pow2_mw, total_mw, energy_halfmj, relay_level, override_active,
                    input ready);
    modport sink   (input valid, volt1_mv, amp1_ma, pow1_mw, volt2_mv, amp2_ma,
                    pow2_mw, total_mw, energy_halfmj, relay_level, override_active,
                    output ready);
endinterface

// ----- hdl/pmlc_ctrl.sv -----
module pmlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pmlc_pkg::t_dp_ctl o_ctl
);
    import pmlc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_commit;
    logic       w_accept;

    // result slot must be free (or draining) before state is touched
    assign w_commit   = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_commit;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_MUL : S_IDLE;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_SUM;
            S_SUM:   n_state = S_UPD;
            S_UPD: begin
                if (w_commit) begin
                    n_state = w_accept ? S_MUL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = w_commit || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ctl.capture  = w_accept;
    assign o_ctl.mul_en   = (r_state == S_MUL);
    assign o_ctl.scale_en = (r_state == S_SCALE);
    assign o_ctl.sum_en   = (r_state == S_SUM);
    assign o_ctl.commit   = w_commit;

endmodule

// ----- hdl/pmlc_dp.sv -----
module pmlc_dp #(
    parameter int ADC_BITS    = pmlc_pkg::ADC_BITS_DEF,
    parameter int ENERGY_BITS = pmlc_pkg::ENERGY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pmlc_pkg::t_dp_ctl               i_ctl,
    input  logic [1:0]                      i_cmd,
    input  logic [ADC_BITS-1:0]             i_adc_v1,
    input  logic [ADC_BITS-1:0]             i_adc_i1,
    input  logic [ADC_BITS-1:0]             i_adc_v2,
    input  logic [ADC_BITS-1:0]             i_adc_i2,
    input  logic                            i_manual_on,
    input  logic                            i_cfg_we,
    input  logic [pmlc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmlc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [pmlc_pkg::VOLT_W-1:0]     o_volt1_mv,
    output logic [pmlc_pkg::AMP_W-1:0]      o_amp1_ma,
    output logic [pmlc_pkg::POW_W-1:0]      o_pow1_mw,
    output logic [pmlc_pkg::VOLT_W-1:0]     o_volt2_mv,
    output logic [pmlc_pkg::AMP_W-1:0]      o_amp2_ma,
    output logic [pmlc_pkg::POW_W-1:0]      o_pow2_mw,
    output logic [pmlc_pkg::TOTAL_W-1:0]    o_total_mw,
    output logic [ENERGY_BITS-1:0]          o_energy_halfmj,
    output logic                            o_relay_level,
    output logic                            o_override_active
);
    import pmlc_pkg::*;

    // captured transaction
    logic [1:0]     r_cmd;
    logic           r_man;
    logic [T_W-1:0] r_tv1, r_ti1, r_tv2, r_ti2;
    logic           w_is_sample;

    // product stages
    logic [VOLT_PW-1:0] r_vp1, r_vp2;
    logic [AMP_PW-1:0]  r_ap1, r_ap2;
    logic [X_W-1:0]     r_x1, r_x2;
    logic [PWR_PW-1:0]  r_pp1, r_pp2;
    logic [POW_W-1:0]   w_p1, w_p2;
    logic [TOTAL_W-1:0] r_total;

    // result fields
    logic [VOLT_W-1:0] r_o_v1, r_o_v2;
    logic [AMP_W-1:0]  r_o_a1, r_o_a2;
    logic [POW_W-1:0]  r_o_p1, r_o_p2;

    // configuration and block state
    logic [THR_W-1:0]       r_thr;
    logic [HOLD_W-1:0]      r_hold_ms;
    logic [TOTAL_W-1:0]     r_last;
    logic                   r_seen;
    logic [ENERGY_BITS-1:0] r_energy;
    logic                   r_relay;
    logic                   r_manual;
    logic [HOLD_W-1:0]      r_hold_left;

    logic [ENERGY_BITS:0]   w_esum;
    logic [ENERGY_BITS-1:0] w_esat;
    logic                   w_total_ok;
    logic                   w_last_ok;

    assign w_is_sample = (i_cmd == CMD_SAMPLE);

    // non-sample transactions carry zero readings so every phase field is zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_man <= i_manual_on;
            r_tv1 <= w_is_sample ? i_adc_v1[ADC_BITS-1 -: T_W] : '0;
            r_ti1 <= w_is_sample ? i_adc_i1[ADC_BITS-1 -: T_W] : '0;
            r_tv2 <= w_is_sample ? i_adc_v2[ADC_BITS-1 -: T_W] : '0;
            r_ti2 <= w_is_sample ? i_adc_i2[ADC_BITS-1 -: T_W] : '0;
        end
        if (i_ctl.mul_en) begin
            r_vp1 <= VOLT_PW'(r_tv1) * VOLT_PW'(VOLT_MUL_C);
            r_vp2 <= VOLT_PW'(r_tv2) * VOLT_PW'(VOLT_MUL_C);
            r_ap1 <= AMP_PW'(r_ti1) * AMP_PW'(AMP_MUL_C);
            r_ap2 <= AMP_PW'(r_ti2) * AMP_PW'(AMP_MUL_C);
            r_x1  <= X_W'(r_tv1) * X_W'(r_ti1);
            r_x2  <= X_W'(r_tv2) * X_W'(r_ti2);
        end
        if (i_ctl.scale_en) begin
            r_pp1 <= PWR_PW'(r_x1) * PWR_PW'(PWR_MUL_C);
            r_pp2 <= PWR_PW'(r_x2) * PWR_PW'(PWR_MUL_C);
        end
        if (i_ctl.sum_en) begin
            r_total <= TOTAL_W'(w_p1) + TOTAL_W'(w_p2);
        end
        if (i_ctl.commit) begin
            r_o_v1 <= r_vp1[VOLT_SH +: VOLT_W];
            r_o_v2 <= r_vp2[VOLT_SH +: VOLT_W];
            r_o_a1 <= r_ap1[AMP_SH +: AMP_W];
            r_o_a2 <= r_ap2[AMP_SH +: AMP_W];
            r_o_p1 <= w_p1;
            r_o_p2 <= w_p2;
        end
    end

    assign w_p1 = r_pp1[PWR_SH +: POW_W];
    assign w_p2 = r_pp2[PWR_SH +: POW_W];

    // saturating energy add, carry out means overflow
    assign w_esum     = {1'b0, r_energy} + (ENERGY_BITS + 1)'(r_total);
    assign w_esat     = w_esum[ENERGY_BITS] ? '1 : w_esum[ENERGY_BITS-1:0];
    assign w_total_ok = (r_total <= r_thr);
    assign w_last_ok  = (r_last <= r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RST;
            r_hold_ms   <= HOLD_RST;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_energy    <= '0;
            r_relay     <= 1'b0;
            r_manual    <= 1'b0;
            r_hold_left <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD: r_thr     <= i_cfg_wdata[THR_W-1:0];
                    CFG_HOLD:      r_hold_ms <= i_cfg_wdata[HOLD_W-1:0];
                endcase
            end
            if (i_ctl.commit) begin
                unique case (r_cmd)
                    CMD_SAMPLE: begin
                        r_last   <= r_total;
                        r_seen   <= 1'b1;
                        r_energy <= w_esat;
                        if (!r_manual) begin
                            r_relay <= w_total_ok;
                        end
                    end
                    CMD_MANUAL: begin
                        r_manual    <= 1'b1;
                        r_relay     <= r_man;
                        r_hold_left <= r_hold_ms;
                    end
                    CMD_TICK: begin
                        if (r_manual) begin
                            if (r_hold_left == '0) begin
                                r_manual <= 1'b0;
                                if (r_seen) begin
                                    r_relay <= w_last_ok;
                                end
                            end else begin
                                r_hold_left <= r_hold_left - 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_volt1_mv        = r_o_v1;
    assign o_amp1_ma         = r_o_a1;
    assign o_pow1_mw         = r_o_p1;
    assign o_volt2_mv        = r_o_v2;
    assign o_amp2_ma         = r_o_a2;
    assign o_pow2_mw         = r_o_p2;
    assign o_total_mw        = r_last;
    assign o_energy_halfmj   = r_energy;
    assign o_relay_level     = r_relay;
    assign o_override_active = r_manual;

endmodule

// ----- hdl/power_meter_load_cutoff.sv -----
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------
// i_in      | in  | valid / ready      | cmd, adc_v1, adc_i1, adc_v2, adc_i2,
//           |     |                    | manual_on
// o_out     | out | valid / ready      | volt/amp/pow per phase, total_mw,
//           |     |                    | energy_halfmj, relay_level, override_active
// i_cfg_*   | in  | write enable only  | index 0 threshold_mw, index 1 hold_ms
//
// One transaction at a time, in steps: top-bit products, power scaling, phase
// sum, state update. Output valid is a register loaded by the update step.
// A new input is taken in the update cycle, so the result register and the
// next transaction overlap; a stalled result holds the update step only.
// Synchronous active-low reset restores the register defaults, clears energy,
// relay off, no override.
module power_meter_load_cutoff #(
    parameter int ADC_BITS    = pmlc_pkg::ADC_BITS_DEF,
    parameter int ENERGY_BITS = pmlc_pkg::ENERGY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pmlc_in_if.sink                         i_in,
    pmlc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [pmlc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmlc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pmlc_pkg::*;

    t_dp_ctl w_ctl;

    // sequencer: owns both handshakes and the result-valid flag
    pmlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (w_ctl)
    );

    // datapath: reciprocal scaling, energy accumulator, relay/override state
    pmlc_dp #(
        .ADC_BITS    (ADC_BITS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_cmd             (i_in.cmd),
        .i_adc_v1          (i_in.adc_v1),
        .i_adc_i1          (i_in.adc_i1),
        .i_adc_v2          (i_in.adc_v2),
        .i_adc_i2          (i_in.adc_i2),
        .i_manual_on       (i_in.manual_on),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_volt1_mv        (o_out.volt1_mv),
        .o_amp1_ma         (o_out.amp1_ma),
        .o_pow1_mw         (o_out.pow1_mw),
        .o_volt2_mv        (o_out.volt2_mv),
        .o_amp2_ma         (o_out.amp2_ma),
        .o_pow2_mw         (o_out.pow2_mw),
        .o_total_mw        (o_out.total_mw),
        .o_energy_halfmj   (o_out.energy_halfmj),
        .o_relay_level     (o_out.relay_level),
        .o_override_active (o_out.override_active)
    );

    // a result shows up only right after an update step
    a_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_ctl.commit))
        else $error("result valid without update step");

    // relay moves only on an update step
    a_relay_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(w_ctl.commit) && $past(i_rst_n)) |-> $stable(o_out.relay_level))
        else $error("relay changed outside update step");

    // override window ends only on an update step
    a_override_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_out.override_active) && $past(i_rst_n)) |-> $past(w_ctl.commit))
        else $error("override ended outside update step");

    // energy never goes down
    a_energy_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_out.energy_halfmj >= $past(o_out.energy_halfmj)))
        else $error("energy accumulator decreased");

endmodule

// ----- bench/meter_check_pkg.sv -----
`timescale 1ns / 100ps

package meter_check_pkg;
    import pmlc_pkg::*;

    localparam int ADC_W        = ADC_BITS_DEF;
    localparam int ENERGY_W     = ENERGY_BITS_DEF;
    localparam int REPORT_LIMIT = 10;

    // cmd code 3 has no function; the block answers it like an idle tick
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [ENERGY_W-1:0] ENERGY_FULL = '1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ADC_W-1:0] adc_v1;
        logic [ADC_W-1:0] adc_i1;
        logic [ADC_W-1:0] adc_v2;
        logic [ADC_W-1:0] adc_i2;
        logic             manual_on;
    } t_meter_item;

    typedef struct packed {
        logic [VOLT_W-1:0]   volt1_mv;
        logic [AMP_W-1:0]    amp1_ma;
        logic [POW_W-1:0]    pow1_mw;
        logic [VOLT_W-1:0]   volt2_mv;
        logic [AMP_W-1:0]    amp2_ma;
        logic [POW_W-1:0]    pow2_mw;
        logic [TOTAL_W-1:0]  total_mw;
        logic [ENERGY_W-1:0] energy_halfmj;
        logic                relay_level;
        logic                override_active;
    } t_meter_reading;

    // Tracks meter state, predicts the reading for every accepted transaction
    // and checks the readings that come back, in order.
    class meter_tracker;
        logic [THR_W-1:0]    threshold;
        logic [HOLD_W-1:0]   hold_cfg;
        logic [TOTAL_W-1:0]  last_total;
        bit                  seen_sample;
        logic [ENERGY_W-1:0] energy;
        bit                  relay;
        bit                  override_on;
        logic [HOLD_W-1:0]   hold_left;
        t_meter_reading      expected_q[$];
        int                  errors;

        function new();
            threshold   = THR_RST;
            hold_cfg    = HOLD_RST;
            last_total  = '0;
            seen_sample = 1'b0;
            energy      = '0;
            relay       = 1'b0;
            override_on = 1'b0;
            hold_left   = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold = data[THR_W-1:0];
                CFG_HOLD:      hold_cfg  = data[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned top_bits(logic [ADC_W-1:0] raw);
            return raw[ADC_W-1 -: T_W];
        endfunction

        function void note_item(t_meter_item it);
            t_meter_reading    r;
            longint unsigned   tv1, ti1, tv2, ti2, p1, p2;
            r = '0;
            case (it.cmd)
                CMD_SAMPLE: begin
                    tv1 = top_bits(it.adc_v1);
                    ti1 = top_bits(it.adc_i1);
                    tv2 = top_bits(it.adc_v2);
                    ti2 = top_bits(it.adc_i2);
                    p1  = tv1 * ti1 * 2400000 / 65025;
                    p2  = tv2 * ti2 * 2400000 / 65025;
                    r.volt1_mv = VOLT_W'(tv1 * 240000 / 255);
                    r.amp1_ma  = AMP_W'(ti1 * 10000 / 255);
                    r.pow1_mw  = POW_W'(p1);
                    r.volt2_mv = VOLT_W'(tv2 * 240000 / 255);
                    r.amp2_ma  = AMP_W'(ti2 * 10000 / 255);
                    r.pow2_mw  = POW_W'(p2);
                    last_total  = TOTAL_W'(p1 + p2);
                    seen_sample = 1'b1;
                    // each sample is 0.5 s, so mW maps 1:1 onto half-mJ
                    if (energy > ENERGY_FULL - ENERGY_W'(last_total))
                        energy = ENERGY_FULL;
                    else
                        energy = energy + ENERGY_W'(last_total);
                    if (!override_on)
                        relay = (last_total <= threshold);
                end
                CMD_MANUAL: begin
                    override_on = 1'b1;
                    relay       = it.manual_on;
                    hold_left   = hold_cfg;
                end
                CMD_TICK: begin
                    if (override_on) begin
                        if (hold_left == 0) begin
                            override_on = 1'b0;
                            if (seen_sample)
                                relay = (last_total <= threshold);
                        end else begin
                            hold_left = hold_left - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.total_mw        = last_total;
            r.energy_halfmj   = energy;
            r.relay_level     = relay;
            r.override_active = override_on;
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want == got)
                return;
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
        endfunction

        function void check_reading(t_meter_reading got);
            t_meter_reading want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("reading arrived with no transaction outstanding");
                return;
            end
            want = expected_q.pop_front();
            check_field("volt1_mv", want.volt1_mv, got.volt1_mv);
            check_field("amp1_ma", want.amp1_ma, got.amp1_ma);
            check_field("pow1_mw", want.pow1_mw, got.pow1_mw);
            check_field("volt2_mv", want.volt2_mv, got.volt2_mv);
            check_field("amp2_ma", want.amp2_ma, got.amp2_ma);
            check_field("pow2_mw", want.pow2_mw, got.pow2_mw);
            check_field("total_mw", want.total_mw, got.total_mw);
            check_field("energy_halfmj", want.energy_halfmj, got.energy_halfmj);
            check_field("relay_level", want.relay_level, got.relay_level);
            check_field("override_active", want.override_active, got.override_active);
        endfunction
    endclass

endpackage

// ----- bench/tb_power_meter_load_cutoff.sv -----
`timescale 1ns / 100ps

module tb_power_meter_load_cutoff;
    import pmlc_pkg::*;
    import meter_check_pkg::*;

    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 130;
    // give stray readings time to show up
    localparam int SETTLE_CYCLES   = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // burst flags: while set, that side never idles
    bit send_burst;
    bit take_burst;

    meter_tracker tracker = new();

    // register settings for the random phases; first one matches reset
    int unsigned thr_plan[N_PHASES]  = '{1500000, 0, 4800000, 23'h7FFFFF,
                                         1200000, 600000, 2400000};
    int unsigned hold_plan[N_PHASES] = '{8000, 0, 65535, 3, 10, 1, 25};

    pmlc_in_if  #(.ADC_BITS(ADC_W))       in_if ();
    pmlc_out_if #(.ENERGY_BITS(ENERGY_W)) out_if ();

    power_meter_load_cutoff #(
        .ADC_BITS    (ADC_W),
        .ENERGY_BITS (ENERGY_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if.sink),
        .o_out       (out_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    initial begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

    // Offer one transaction after a random idle gap and hold it until taken.
    // Valid stays high across back-to-back transactions, so it never gets two
    // updates in the same step.
    task automatic send_item(t_meter_item it);
        int gap;
        if ($urandom_range(0, 23) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : int'($urandom_range(0, 13));
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.cmd       <= it.cmd;
        in_if.adc_v1    <= it.adc_v1;
        in_if.adc_i1    <= it.adc_i1;
        in_if.adc_v2    <= it.adc_v2;
        in_if.adc_i2    <= it.adc_i2;
        in_if.manual_on <= it.manual_on;
        in_if.valid     <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.note_item(it);
    endtask

    task automatic send_fields(logic [1:0] cmd, logic [ADC_W-1:0] v1, logic [ADC_W-1:0] i1,
                               logic [ADC_W-1:0] v2, logic [ADC_W-1:0] i2, logic on);
        t_meter_item it;
        it.cmd       = cmd;
        it.adc_v1    = v1;
        it.adc_i1    = i1;
        it.adc_v2    = v2;
        it.adc_i2    = i2;
        it.manual_on = on;
        send_item(it);
    endtask

    // Stop offering and wait for every outstanding reading.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // One-cycle write pulse, then write enable is held low before the task returns.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Readings lean toward the rails so zero and full scale come up often.
    function automatic logic [ADC_W-1:0] random_reading();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
        endcase
    endfunction

    // Mix: mostly samples and ticks, enough manual commands to keep override
    // windows opening, a few reserved codes.
    function automatic t_meter_item random_item();
        t_meter_item it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.cmd = CMD_SAMPLE;
        else if (pick < 57)
            it.cmd = CMD_MANUAL;
        else if (pick < 95)
            it.cmd = CMD_TICK;
        else
            it.cmd = CMD_RESERVED;
        it.adc_v1    = random_reading();
        it.adc_i1    = random_reading();
        it.adc_v2    = random_reading();
        it.adc_i2    = random_reading();
        it.manual_on = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Reading sink: random back-pressure, every accepted reading is checked.
    initial begin
        int             take_gap;
        t_meter_reading seen;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 23) == 0)
                take_burst = !take_burst;
            take_gap = take_burst ? 0 : int'($urandom_range(0, 13));
            if (take_gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (take_gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            seen.volt1_mv        = out_if.volt1_mv;
            seen.amp1_ma         = out_if.amp1_ma;
            seen.pow1_mw         = out_if.pow1_mw;
            seen.volt2_mv        = out_if.volt2_mv;
            seen.amp2_ma         = out_if.amp2_ma;
            seen.pow2_mw         = out_if.pow2_mw;
            seen.total_mw        = out_if.total_mw;
            seen.energy_halfmj   = out_if.energy_halfmj;
            seen.relay_level     = out_if.relay_level;
            seen.override_active = out_if.override_active;
            tracker.check_reading(seen);
        end
    end

    // Main sequence.
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_THRESHOLD;
        i_cfg_wdata     <= '0;
        in_if.valid     <= 1'b0;
        in_if.cmd       <= CMD_SAMPLE;
        in_if.adc_v1    <= '0;
        in_if.adc_i1    <= '0;
        in_if.adc_v2    <= '0;
        in_if.adc_i2    <= '0;
        in_if.manual_on <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset register values ---
        // tick with no override open: nothing moves
        send_fields(CMD_TICK, '0, '0, '0, '0, 1'b0);
        // reserved code, full-scale junk on the ADC fields: ignored
        send_fields(CMD_RESERVED, '1, '1, '1, '1, 1'b1);
        // manual on opens the window with the reset hold time
        send_fields(CMD_MANUAL, '0, '0, '0, '0, 1'b1);
        send_fields(CMD_TICK, '0, '0, '0, '0, 1'b0);
        // second command restarts the window and drops the relay
        send_fields(CMD_MANUAL, '0, '0, '0, '0, 1'b0);

        // zero hold: the first tick after a command ends the override
        drain();
        write_reg(CFG_HOLD, '0);
        // expiry with no sample ever seen: relay keeps the manual level
        send_fields(CMD_MANUAL, '0, '0, '0, '0, 1'b1);
        send_fields(CMD_TICK, '0, '0, '0, '0, 1'b0);
        // zero and full scale, then codes that differ only in dropped low bits
        send_fields(CMD_SAMPLE, '0, '0, '0, '0, 1'b0);
        send_fields(CMD_SAMPLE, '1, '1, '1, '1, 1'b0);
        send_fields(CMD_SAMPLE, 12'h00F, 12'h00F, 12'h00F, 12'h00F, 1'b1);
        send_fields(CMD_SAMPLE, 12'hFF0, 12'hFF0, 12'hFF0, 12'hFF0, 1'b0);
        send_fields(CMD_SAMPLE, 12'h800, 12'h7FF, 12'h0AB, 12'hF5E, 1'b0);
        // sample inside override: energy moves, relay held; expiry re-evaluates
        send_fields(CMD_MANUAL, '0, '0, '0, '0, 1'b1);
        send_fields(CMD_SAMPLE, '1, '1, '1, '1, 1'b0);
        send_fields(CMD_TICK, '0, '0, '0, '0, 1'b0);
        send_fields(CMD_TICK, '0, '0, '0, '0, 1'b1);

        // threshold boundary: full-scale phase one alone is exactly 2400000 mW
        drain();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(2400000));
        send_fields(CMD_SAMPLE, '1, '1, '0, '0, 1'b0);
        drain();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(2399999));
        send_fields(CMD_SAMPLE, '1, '1, '0, '0, 1'b0);
        // new threshold picked up at override expiry, not at the write
        send_fields(CMD_MANUAL, '0, '0, '0, '0, 1'b0);
        drain();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(4800000));
        send_fields(CMD_TICK, '0, '0, '0, '0, 1'b0);

        // --- random phases, one register setting each ---
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr_plan[p]));
            write_reg(CFG_HOLD, CFG_DATA_W'(hold_plan[p]));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item());
                // now and then let the pipe run completely dry
                if ($urandom_range(0, 63) == 0)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
